[rtl/mso_pkg.sv]
// Shared types, constants and scoring helpers for the move score and order block.
package mso_pkg;

	localparam int LIST_DEPTH_DEF = 256;
	localparam int MOVE_BITS_DEF  = 16;
	localparam int SCORE_BITS     = 32;
	localparam int CFG_BITS       = 31;
	localparam int CAP_BITS       = 19;

	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_PULL  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [2:0] REG_TABLE_MOVE    = 3'd0;
	localparam logic [2:0] REG_KILLER_FIRST  = 3'd1;
	localparam logic [2:0] REG_KILLER_SECOND = 3'd2;
	localparam logic [2:0] REG_GOOD_BONUS    = 3'd3;
	localparam logic [2:0] REG_BAD_BONUS     = 3'd4;
	localparam logic [2:0] REG_TABLE_BONUS   = 3'd5;
	localparam logic [2:0] REG_KF_BONUS      = 3'd6;
	localparam logic [2:0] REG_KS_BONUS      = 3'd7;

	typedef struct packed {
		logic        [15:0]         table_move;
		logic        [15:0]         killer_first;
		logic        [15:0]         killer_second;
		logic signed [CFG_BITS-1:0] good_bonus;
		logic signed [CFG_BITS-1:0] bad_bonus;
		logic signed [CFG_BITS-1:0] table_bonus;
		logic signed [CFG_BITS-1:0] kf_bonus;
		logic signed [CFG_BITS-1:0] ks_bonus;
	} cfg_t;

	function automatic logic [14:0] piece_val(input logic [2:0] t);
		logic [14:0] v;
		unique case (t)
			3'd1: v = 15'd100;
			3'd2: v = 15'd320;
			3'd3: v = 15'd330;
			3'd4: v = 15'd500;
			3'd5: v = 15'd900;
			3'd6: v = 15'd20000;
			default: v = 15'd0;
		endcase
		return v;
	endfunction

	// victim value times ten minus attacker value
	function automatic logic signed [CAP_BITS-1:0] cap_base(input logic [2:0] victim,
			input logic [2:0] attacker);
		logic [CAP_BITS-2:0] pv;
		logic [CAP_BITS-2:0] pa;
		pv = (CAP_BITS-1)'(piece_val(victim)) * (CAP_BITS-1)'(10);
		pa = (CAP_BITS-1)'(piece_val(attacker));
		return $signed({1'b0, pv}) - $signed({1'b0, pa});
	endfunction

endpackage

[rtl/move_score_and_order.sv]
// Top level of the move score and order block: control sequencer, config and output.
//
// Keeps one node's move list in a memory, sorted by descending score with ties in
// load order. A load scores the move in the scorer pipeline, then walks the list from
// its tail toward the read position, one read and one write-back per entry moved; the
// entries moved are the not yet pulled ones that score below it (at most
// LIST_DEPTH - 1), and the walk stops at an entry that scores at least as high or at
// the read position. A pull does one memory read, an empty pull or a clear none; the
// list memory has a single read port. Loads into a full list are dropped. The result
// register holds a pull until taken; loads and clears go on meanwhile, a further pull
// waits for it. Config registers are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while idle, as the block itself does not enforce it.
module move_score_and_order #(
	parameter int LIST_DEPTH = mso_pkg::LIST_DEPTH_DEF,
	parameter int MOVE_BITS  = mso_pkg::MOVE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [2:0]                            cfg_index,
	input  logic [mso_pkg::CFG_BITS-1:0]          cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            func,
	input  logic [MOVE_BITS-1:0]                  move_code,
	input  logic                                  cap_flag,
	input  logic                                  quiet_flag,
	input  logic [2:0]                            victim_type,
	input  logic [2:0]                            attacker_type,
	input  logic                                  see_passes,
	input  logic signed [mso_pkg::CFG_BITS-1:0]   history_sum,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [MOVE_BITS-1:0]                  best_move,
	output logic signed [mso_pkg::SCORE_BITS-1:0] best_score,
	output logic                                  list_empty
);
	import mso_pkg::*;

	localparam int AW = $clog2(LIST_DEPTH);
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int EW = MOVE_BITS + SCORE_BITS;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCORE = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_CMP   = 3'd3;
	localparam logic [2:0] ST_PULL  = 3'd4;

	logic [2:0]           state_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        rd_q;
	logic [CW-1:0]        pos_q;
	logic [MOVE_BITS-1:0] move_q;
	cfg_t                 cfg_q;
	logic                 accept;
	logic                 load_go;
	logic signed [SCORE_BITS-1:0] new_score;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;
	logic [CW-1:0] pos_prev;

	// a pull needs the result register free; loads and clears do not
	assign in_ready = (state_q == ST_IDLE) && (!out_valid || out_ready || func != FUNC_PULL);
	assign accept   = in_valid && in_ready;
	assign load_go  = accept && func == FUNC_LOAD && cnt_q != CW'(LIST_DEPTH);
	assign pos_prev = pos_q - CW'(1);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TABLE_MOVE:    cfg_q.table_move    <= cfg_data[15:0];
				REG_KILLER_FIRST:  cfg_q.killer_first  <= cfg_data[15:0];
				REG_KILLER_SECOND: cfg_q.killer_second <= cfg_data[15:0];
				REG_GOOD_BONUS:    cfg_q.good_bonus    <= cfg_data;
				REG_BAD_BONUS:     cfg_q.bad_bonus     <= cfg_data;
				REG_TABLE_BONUS:   cfg_q.table_bonus   <= cfg_data;
				REG_KF_BONUS:      cfg_q.kf_bonus      <= cfg_data;
				REG_KS_BONUS:      cfg_q.ks_bonus      <= cfg_data;
				default: ;
			endcase
		end
	end

	mso_scorer #(.MOVE_BITS(MOVE_BITS)) u_scorer (
		.clk           (clk),
		.en            (load_go),
		.cfg           (cfg_q),
		.move_code     (move_code),
		.cap_flag      (cap_flag),
		.quiet_flag    (quiet_flag),
		.victim_type   (victim_type),
		.attacker_type (attacker_type),
		.see_passes    (see_passes),
		.history_sum   (history_sum),
		.score         (new_score)
	);

	mso_list_ram #(.DEPTH(LIST_DEPTH), .WIDTH(EW)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// memory port steering: shift an entry down one place, or drop the new move in
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q[AW-1:0];
		ram_wdata = {move_q, new_score};
		ram_re    = 1'b0;
		ram_raddr = pos_prev[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (accept && func == FUNC_PULL && rd_q < cnt_q) begin
					ram_re    = 1'b1;
					ram_raddr = rd_q[AW-1:0];
				end
			end
			ST_SCAN: begin
				if (pos_q > rd_q) begin
					ram_re = 1'b1;
				end else begin
					ram_we = 1'b1;
				end
			end
			ST_CMP: begin
				ram_we = 1'b1;
				if ($signed(ram_rdata[SCORE_BITS-1:0]) < new_score) begin
					ram_wdata = ram_rdata;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rd_q    <= '0;
			pos_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (load_go) begin
						pos_q   <= cnt_q;
						state_q <= ST_SCORE;
					end else if (accept && func == FUNC_PULL && rd_q < cnt_q) begin
						state_q <= ST_PULL;
					end else if (accept && func == FUNC_CLEAR) begin
						cnt_q <= '0;
						rd_q  <= '0;
					end
				end
				ST_SCORE: state_q <= ST_SCAN;
				ST_SCAN: begin
					if (pos_q > rd_q) begin
						state_q <= ST_CMP;
					end else begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_CMP: begin
					if ($signed(ram_rdata[SCORE_BITS-1:0]) < new_score) begin
						pos_q   <= pos_prev;
						state_q <= ST_SCAN;
					end else begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_PULL: begin
					rd_q    <= rd_q + CW'(1);
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// hold the move of a load for the insertion walk
	always_ff @(posedge clk) begin
		if (load_go) begin
			move_q <= move_code;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_PULL ||
				(accept && func == FUNC_PULL && !(rd_q < cnt_q))) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PULL) begin
			best_move  <= ram_rdata[EW-1:SCORE_BITS];
			best_score <= $signed(ram_rdata[SCORE_BITS-1:0]);
			list_empty <= 1'b0;
		end else if (accept && func == FUNC_PULL && !(rd_q < cnt_q)) begin
			best_move  <= '0;
			best_score <= '0;
			list_empty <= 1'b1;
		end
	end

	a_rd_le_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rd_q <= cnt_q) else $error("read position passed entry count");
	a_cnt_le_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(LIST_DEPTH)) else $error("entry count beyond list depth");
	a_pos_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_CMP) |-> (pos_q >= rd_q && pos_q <= cnt_q))
		else $error("insert position outside unread window");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n && accept && func == FUNC_PULL && !(rd_q < cnt_q))
		|-> (out_valid && list_empty))
		else $error("empty pull gave no empty mark");
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("ready while walking list");

endmodule

[rtl/mso_scorer.sv]
// Two-stage scorer: partial sums, then final add with 32-bit saturation.
module mso_scorer #(
	parameter int MOVE_BITS = mso_pkg::MOVE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  mso_pkg::cfg_t                        cfg,
	input  logic [MOVE_BITS-1:0]                 move_code,
	input  logic                                 cap_flag,
	input  logic                                 quiet_flag,
	input  logic [2:0]                           victim_type,
	input  logic [2:0]                           attacker_type,
	input  logic                                 see_passes,
	input  logic signed [mso_pkg::CFG_BITS-1:0]  history_sum,
	output logic signed [mso_pkg::SCORE_BITS-1:0] score
);
	import mso_pkg::*;

	logic signed [CFG_BITS+1:0] cap_sum;
	logic signed [CFG_BITS:0]   oth_sum;
	logic signed [CFG_BITS-1:0] quiet_term;
	logic signed [CFG_BITS-1:0] tbl_term;
	logic                       tbl_hit;
	logic                       kf_hit;
	logic                       ks_hit;
	logic signed [CFG_BITS+1:0] cap_s1;
	logic signed [CFG_BITS:0]   oth_s1;
	logic signed [CFG_BITS+2:0] total;

	always_comb begin
		tbl_hit = (cfg.table_move != 16'd0) && (move_code == MOVE_BITS'(cfg.table_move));
		kf_hit  = (cfg.killer_first != 16'd0) && (move_code == MOVE_BITS'(cfg.killer_first));
		ks_hit  = (cfg.killer_second != 16'd0) && (move_code == MOVE_BITS'(cfg.killer_second));
		if (cap_flag) begin
			cap_sum = (CFG_BITS+2)'(cap_base(victim_type, attacker_type))
				+ (CFG_BITS+2)'(see_passes ? cfg.good_bonus : cfg.bad_bonus);
		end else begin
			cap_sum = '0;
		end
		tbl_term = tbl_hit ? cfg.table_bonus : '0;
		priority if (!quiet_flag) begin
			quiet_term = '0;
		end else if (kf_hit) begin
			quiet_term = cfg.kf_bonus;
		end else if (ks_hit) begin
			quiet_term = cfg.ks_bonus;
		end else begin
			quiet_term = history_sum;
		end
		oth_sum = (CFG_BITS+1)'(tbl_term) + (CFG_BITS+1)'(quiet_term);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cap_s1 <= cap_sum;
			oth_s1 <= oth_sum;
		end
	end

	assign total = (CFG_BITS+3)'(cap_s1) + (CFG_BITS+3)'(oth_s1);

	// saturate to the signed 32-bit range
	always_ff @(posedge clk) begin
		if (total > (CFG_BITS+3)'(32'sh7FFFFFFF)) begin
			score <= 32'sh7FFFFFFF;
		end else if (total < (CFG_BITS+3)'(-33'sd2147483648)) begin
			score <= 32'sh80000000;
		end else begin
			score <= SCORE_BITS'(total);
		end
	end

endmodule

[rtl/mso_list_ram.sv]
// Single-port-write, registered-read memory holding move and score of each entry.
module mso_list_ram #(
	parameter int DEPTH = mso_pkg::LIST_DEPTH_DEF,
	parameter int WIDTH = mso_pkg::MOVE_BITS_DEF + mso_pkg::SCORE_BITS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
